### rtl/stk_pkg.sv
// ----------------------------------------------------------------------------
// stk_pkg
// Shared types and constants for the script tokenizer: payload words,
// scan modes, result kinds and register indexes.
// ----------------------------------------------------------------------------
package stk_pkg;

   // Token and line counter sizing
   localparam int MAX_TOKEN = 64;
   localparam int LINE_BITS = 16;
   localparam int LEN_BITS  = $clog2(MAX_TOKEN);

   localparam logic [LEN_BITS-1:0]  FULL_LEN = LEN_BITS'(MAX_TOKEN - 1);
   localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
   localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

   // Byte classes
   localparam logic [7:0] SPACE_MAX = 8'd32;
   localparam logic [7:0] NL_BYTE   = 8'd10;

   // Register reset values
   localparam logic [7:0] COMMENT_RESET = 8'd59;
   localparam logic [7:0] QUOTE_RESET   = 8'd34;

   // Register indexes
   localparam logic CSR_COMMENT = 1'b0;
   localparam logic CSR_QUOTE   = 1'b1;

   // Request opcodes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_EOS  = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_CHAR = 2'd0;
   localparam logic [1:0] KIND_LAST = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

   typedef enum logic [2:0] {
      MODE_BETWEEN,
      MODE_COMMENT,
      MODE_PLAIN,
      MODE_QUOTED,
      MODE_DROP
   } mode_type;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  token_char;
      logic [15:0] line_number;
      logic        is_quoted;
      logic        crossed_line;
      logic [5:0]  char_count;
   } rsp_type;

   // Delimiter settings handed to the scanner
   typedef struct packed {
      logic [7:0] comment_char;
      logic [7:0] quote_char;
   } cfg_type;

endpackage

### rtl/stk_scan.sv
// ----------------------------------------------------------------------------
// stk_scan
// Tokenizer state (mode, token length, line count, crossed flag) and the
// update that turns one request word into at most one result.
// ----------------------------------------------------------------------------
module stk_scan (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  stk_pkg::req_type req,
   input  stk_pkg::cfg_type cfg,
   output logic            res_valid,
   output stk_pkg::rsp_type res
);
   import stk_pkg::*;

   mode_type             mode_ff, mode_in;
   logic [LEN_BITS-1:0]  len_ff, len_in;
   logic [LINE_BITS-1:0] line_ff, line_in;
   logic                 crossed_ff, crossed_in;

   logic [7:0]           b;
   logic                 is_space;
   logic                 is_nl;
   logic                 is_comment;
   logic                 is_quote;
   logic [LINE_BITS-1:0] line_inc;
   logic [LEN_BITS-1:0]  len_next;
   logic [LEN_BITS-1:0]  put_len;

   assign b          = req.data_byte;
   assign is_space   = (b <= SPACE_MAX);
   assign is_nl      = (b == NL_BYTE);
   assign is_comment = (b == cfg.comment_char);
   assign is_quote   = (b == cfg.quote_char);
   assign line_inc   = (line_ff != LINE_MAX) ? line_ff + LINE_ONE : line_ff;
   assign len_next   = len_ff + LEN_BITS'(1);

   // Next state and result
   always_comb begin
      mode_in        = mode_ff;
      len_in         = len_ff;
      line_in        = line_ff;
      crossed_in     = crossed_ff;
      res_valid      = 1'b0;
      res.kind       = KIND_END;
      res.token_char = 8'd0;
      res.is_quoted  = 1'b0;
      put_len        = len_ff;

      if (req.op == OP_EOS) begin
         if (mode_ff == MODE_PLAIN || mode_ff == MODE_QUOTED) begin
            res_valid     = 1'b1;
            res.is_quoted = (mode_ff == MODE_QUOTED);
         end
         mode_in    = MODE_BETWEEN;
         len_in     = '0;
         line_in    = LINE_ONE;
         crossed_in = 1'b0;
      end else begin
         unique case (mode_ff)
            MODE_COMMENT: begin
               if (is_nl) begin
                  line_in    = line_inc;
                  crossed_in = 1'b1;
                  mode_in    = MODE_BETWEEN;
               end
            end
            MODE_PLAIN: begin
               if (is_space || is_comment) begin
                  // token end word, then the byte is seen between tokens
                  res_valid  = 1'b1;
                  len_in     = '0;
                  crossed_in = 1'b0;
                  mode_in    = MODE_BETWEEN;
                  if (is_space) begin
                     if (is_nl) begin
                        line_in    = line_inc;
                        crossed_in = 1'b1;
                     end
                  end else begin
                     mode_in = MODE_COMMENT;
                  end
               end else begin
                  res_valid      = 1'b1;
                  res.token_char = b;
                  put_len        = len_next;
                  if (len_next >= FULL_LEN) begin
                     res.kind   = KIND_LAST;
                     len_in     = '0;
                     crossed_in = 1'b0;
                     mode_in    = MODE_BETWEEN;
                  end else begin
                     res.kind = KIND_CHAR;
                     len_in   = len_next;
                  end
               end
            end
            MODE_QUOTED: begin
               res_valid     = 1'b1;
               res.is_quoted = 1'b1;
               if (is_quote) begin
                  len_in     = '0;
                  crossed_in = 1'b0;
                  mode_in    = MODE_BETWEEN;
               end else begin
                  res.token_char = b;
                  put_len        = len_next;
                  if (len_next >= FULL_LEN) begin
                     res.kind   = KIND_LAST;
                     len_in     = '0;
                     crossed_in = 1'b0;
                     mode_in    = MODE_DROP;
                  end else begin
                     res.kind = KIND_CHAR;
                     len_in   = len_next;
                  end
               end
            end
            MODE_DROP: begin
               mode_in = MODE_BETWEEN;
            end
            default: begin
               // between tokens
               mode_in = MODE_BETWEEN;
               if (is_space) begin
                  if (is_nl) begin
                     line_in    = line_inc;
                     crossed_in = 1'b1;
                  end
               end else if (is_comment) begin
                  mode_in = MODE_COMMENT;
               end else if (is_quote) begin
                  mode_in = MODE_QUOTED;
                  len_in  = '0;
               end else begin
                  res_valid      = 1'b1;
                  res.token_char = b;
                  put_len        = LEN_BITS'(1);
                  if (LEN_BITS'(1) >= FULL_LEN) begin
                     res.kind   = KIND_LAST;
                     len_in     = '0;
                     crossed_in = 1'b0;
                  end else begin
                     res.kind = KIND_CHAR;
                     len_in   = LEN_BITS'(1);
                     mode_in  = MODE_PLAIN;
                  end
               end
            end
         endcase
      end

      res.line_number  = 16'(line_ff);
      res.crossed_line = crossed_ff;
      res.char_count   = 6'(put_len);
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_BETWEEN;
         len_ff     <= '0;
         line_ff    <= LINE_ONE;
         crossed_ff <= 1'b0;
      end else if (step) begin
         mode_ff    <= mode_in;
         len_ff     <= len_in;
         line_ff    <= line_in;
         crossed_ff <= crossed_in;
      end
   end

endmodule

### rtl/script_tokenizer.sv
// ----------------------------------------------------------------------------
// script_tokenizer
// Byte-serial script tokenizer with comment and quote handling.
// ----------------------------------------------------------------------------
// Takes one script byte (or an end-of-script word) per cycle and returns at
// most one result per byte: each token character with line number, quoted and
// line-crossed flags, plus an end word when a token is closed by a delimiter
// or by end of script. A word is held in the input register, and as the
// tokenizer state updates, the result lands in the output register;
// throughput is one word per cycle while rsp_stall is low. comment_char and
// quote_char are written through the csr port; the user must write them only
// while the block is idle, as the block itself does not enforce it.
module script_tokenizer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stk_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stk_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [7:0]       csr_wdata
);
   import stk_pkg::*;

   req_type in_data_ff;
   logic    in_valid_ff;
   rsp_type out_data_ff;
   logic    out_valid_ff;
   cfg_type cfg_ff;
   logic    step;
   logic    res_valid;
   rsp_type res;

   // Advance when the output register is free or being drained
   assign step      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !step;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   stk_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .req       (in_data_ff),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= res_valid;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid) begin
         out_data_ff <= res;
      end
   end

   // Delimiter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.comment_char <= COMMENT_RESET;
         cfg_ff.quote_char   <= QUOTE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COMMENT: cfg_ff.comment_char <= csr_wdata;
            CSR_QUOTE:   cfg_ff.quote_char   <= csr_wdata;
            default:     cfg_ff <= cfg_ff;
         endcase
      end
   end

endmodule
